>>> hw/rtl/lsts_pkg.sv
// ============================================================================
// lsts_pkg
// Shared types and constants for the line start table search block.
// ============================================================================
package lsts_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int MODE_W      = 2;
    localparam int POS_W       = 31;
    localparam int LINE_W      = 11;
    localparam int COL_W       = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // Mode codes on the input tuser
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_LOOKUP,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
    } cmd_t;

    // Handshake between the front queue and the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_NEXT,
        ST_EMIT
    } state_t;

endpackage

>>> hw/rtl/lsts_front.sv
// ============================================================================
// lsts_front
// Accepts input requests, decodes the mode and queues commands.
// ============================================================================
module lsts_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsts_pkg::IN_TDATA_W-1:0] s_tdata,  // [30:0] position
    input  logic [lsts_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
    output lsts_pkg::cmd_req_t             cmd_req,
    input  logic                           cmd_pop
);
    import lsts_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;
    cmd_t              in_cmd;

    // Decode the mode; the unused code becomes a no-op
    always_comb begin
        in_cmd.position = s_tdata[POS_W-1:0];
        case (s_tuser)
            MODE_APPEND: in_cmd.op = OP_APPEND;
            MODE_LOOKUP: in_cmd.op = OP_LOOKUP;
            MODE_CLEAR:  in_cmd.op = OP_CLEAR;
            default:     in_cmd.op = OP_NOP;
        endcase
    end

    assign s_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = cmd_pop && (cnt_reg != '0);

    assign cmd_req.valid = (cnt_reg != '0);
    assign cmd_req.cmd   = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> hw/rtl/lsts_back.sv
// ============================================================================
// lsts_back
// Executes queued commands: table append, clear and binary-search lookup.
// ============================================================================
module lsts_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lsts_pkg::cmd_req_t              cmd_req,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsts_pkg::OUT_TDATA_W-1:0] m_tdata,  // [10:0] line, [42:11] column
    output logic                            m_tuser    // [0] table_full
);
    import lsts_pkg::*;

    // Line start table; entry 0 is never written and always reads as zero
    logic [POS_W-1:0]  mem [TABLE_DEPTH];
    logic [POS_W-1:0]  rd_data_reg;
    logic              rd_zero_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [POS_W-1:0]  rd_eff;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  p_reg, p_next;
    logic [LINE_W-1:0] line_res_reg, line_res_next;
    logic [COL_W-1:0]  col_res_reg, col_res_next;
    logic              full_res_reg, full_res_next;

    logic              m_valid_reg, m_valid_next;
    logic [LINE_W-1:0] m_line_reg, m_line_next;
    logic [COL_W-1:0]  m_col_reg, m_col_next;
    logic              m_full_reg, m_full_next;

    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [LINE_W-1:0] k_line;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign rd_eff  = rd_zero_reg ? '0 : rd_data_reg;
    assign k_line  = LINE_W'({1'b0, k_reg} + (IDX_W + 1)'(1));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        p_next        = p_reg;
        line_res_next = line_res_reg;
        col_res_next  = col_res_reg;
        full_res_next = full_res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_line_next   = m_line_reg;
        m_col_next    = m_col_reg;
        m_full_next   = m_full_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        rd_addr       = mid;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_req.valid) begin
                    cmd_pop       = 1'b1;
                    pos_next      = cmd_req.cmd.position;
                    line_res_next = '0;
                    col_res_next  = '0;
                    full_res_next = 1'b0;
                    state_next    = ST_EMIT;
                    case (cmd_req.cmd.op)
                        OP_APPEND: begin
                            if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                full_res_next = 1'b1;
                            end
                        end
                        OP_LOOKUP: begin
                            lo_next    = '0;
                            hi_next    = IDX_W'(count_reg - CNT_W'(1));
                            state_next = ST_PROBE;
                        end
                        OP_CLEAR: begin
                            count_next = CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                rd_addr    = mid;
                k_next     = mid;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                p_next = rd_eff;
                if (pos_reg < rd_eff) begin
                    if (k_reg == lo_reg) begin
                        // search ran out: no entry at or below the offset
                        line_res_next = LINE_W'(1);
                        col_res_next  = COL_W'(pos_reg) + COL_W'(1);
                        state_next    = ST_EMIT;
                    end else begin
                        hi_next    = k_reg - IDX_W'(1);
                        state_next = ST_PROBE;
                    end
                end else if (k_reg < hi_reg) begin
                    rd_addr    = k_reg + IDX_W'(1);
                    state_next = ST_NEXT;
                end else begin
                    line_res_next = k_line;
                    col_res_next  = COL_W'(pos_reg) - COL_W'(rd_eff) + COL_W'(1);
                    state_next    = ST_EMIT;
                end
            end
            ST_NEXT: begin
                if (pos_reg >= rd_eff) begin
                    lo_next    = k_reg + IDX_W'(1);
                    state_next = ST_PROBE;
                end else begin
                    line_res_next = k_line;
                    col_res_next  = COL_W'(pos_reg) - COL_W'(p_reg) + COL_W'(1);
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_line_next  = line_res_reg;
                    m_col_next   = col_res_reg;
                    m_full_next  = full_res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        p_reg        <= p_next;
        line_res_reg <= line_res_next;
        col_res_reg  <= col_res_next;
        full_res_reg <= full_res_next;
        m_line_reg   <= m_line_next;
        m_col_reg    <= m_col_next;
        m_full_reg   <= m_full_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[IDX_W-1:0]] <= pos_next;
        end
        rd_data_reg <= mem[rd_addr];
        rd_zero_reg <= (rd_addr == '0);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - LINE_W - COL_W){1'b0}}, m_col_reg, m_line_reg};
    assign m_tuser  = m_full_reg;

endmodule

>>> hw/rtl/line_start_table_search.sv
// ============================================================================
// line_start_table_search
// Line start offset table with append, clear and line/column lookup.
// ============================================================================
// Usage:
//   Input stream (s_*): one request per item. s_tuser carries the mode
//   (append, lookup, clear; the fourth code is a no-op), s_tdata the byte
//   offset. Result stream (m_*): exactly one result per request, in order.
//   m_tdata carries line and column, m_tuser the table full flag.
//   Flow: a request lands in a two-entry command queue, then the
//   execution engine takes it. With the engine idle and the output
//   register free, append, clear and no-op go from the idle state to
//   the emit state and raise m_tvalid from the output register. A lookup
//   runs a binary search with one table memory that has one write port
//   and one registered read port: each probe passes the probe and
//   compare states, and also the next state when the next entry must be
//   read, for at most log2(TABLE_DEPTH)+1 probes.
//   Throughput: one request in execution at a time; the queue lets the
//   sender push two more while a search runs or the receiver stalls.
//   Reset: the table holds the single entry 0 (offset 0); queue and
//   output register empty. No clearing pass is needed.
//   Stall: while m_tready is low the result holds in the output register,
//   the engine waits with its next result, then the queue fills and
//   s_tready drops.
// ============================================================================
module line_start_table_search (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsts_pkg::IN_TDATA_W-1:0]  s_tdata,   // [30:0] position
    input  logic [lsts_pkg::MODE_W-1:0]      s_tuser,   // [1:0] mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsts_pkg::OUT_TDATA_W-1:0] m_tdata,   // [10:0] line, [42:11] column
    output logic                             m_tuser    // [0] table_full
);
    import lsts_pkg::*;

    cmd_req_t cmd_req;
    logic     cmd_pop;

    // Front end: request intake, mode decode, command queue
    lsts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_req  (cmd_req),
        .cmd_pop  (cmd_pop)
    );

    // Back end: table memory, search engine, output register
    lsts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_req  (cmd_req),
        .cmd_pop  (cmd_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Engine only pops a queue that holds a command
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_req.valid)
    else $error("command popped from empty queue");

    // A dropped append reports line and column zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[LINE_W+COL_W-1:0] == '0))
    else $error("table full result with nonzero line or column");

    // Line and column are both zero (append/clear/no-op) or both nonzero (lookup)
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[LINE_W-1:0] == '0)
                      == (m_tdata[LINE_W+COL_W-1:LINE_W] == '0)))
    else $error("line and column disagree on result kind");

    // Queue full implies the engine is holding it back: no intake then
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && !cmd_pop) |=> !s_tready)
    else $error("queue drained without a pop");

endmodule

>>> dv/lsts_line_col_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lsts_line_col_checker
// Watches both streams of the line start table search block, keeps its own
// copy of the offset table, predicts the line/column answer of every
// accepted request and compares each returned result against it.
// ============================================================================
module lsts_line_col_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lsts_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [lsts_pkg::MODE_W-1:0]      s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lsts_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tuser,
    output int                               mismatch_count,
    output int                               outstanding
);
    import lsts_pkg::*;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic              full;
    } line_col_t;

    // Shadow table; only entries below shadow_count are ever probed.
    logic [POS_W-1:0] starts_shadow [TABLE_DEPTH];
    int               shadow_count;
    line_col_t        line_col_q [$];

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        shadow_count   = 1;
        starts_shadow[0] = '0;
    end

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch: %s got 0x%0h want 0x%0h at %0t ns", field, got, want, $time);
        mismatch_count++;
    endtask

    // Same probe order as the block: midpoint, then step right only while
    // the next entry still qualifies.
    function automatic line_col_t find_line(input logic [POS_W-1:0] pos);
        line_col_t  r;
        int         lo;
        int         hi;
        int         k;
        int         line_num;
        r  = '0;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
            k = (lo + hi) / 2;
            if (pos < starts_shadow[k]) begin
                hi = k - 1;
            end else if (k < hi && pos >= starts_shadow[k+1]) begin
                lo = k + 1;
            end else begin
                line_num = k + 1;
                r.line   = line_num[LINE_W-1:0];
                r.column = {1'b0, pos} - {1'b0, starts_shadow[k]} + 32'd1;
                return r;
            end
        end
        // no entry at or below pos
        r.line   = LINE_W'(1);
        r.column = {1'b0, pos} + 32'd1;
        return r;
    endfunction

    function automatic line_col_t apply_request(input op_t op, input logic [POS_W-1:0] pos);
        line_col_t r;
        r = '0;
        case (op)
            OP_APPEND: begin
                if (shadow_count < TABLE_DEPTH) begin
                    starts_shadow[shadow_count] = pos;
                    shadow_count++;
                end else begin
                    r.full = 1'b1;
                end
            end
            OP_LOOKUP: r = find_line(pos);
            OP_CLEAR:  shadow_count = 1;
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        line_col_t want;
        line_col_t got;
        if (!aresetn) begin
            line_col_q.delete();
            shadow_count = 1;
            starts_shadow[0] = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.line   = m_tdata[LINE_W-1:0];
                got.column = m_tdata[LINE_W+COL_W-1:LINE_W];
                got.full   = m_tuser;
                if (line_col_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 64'(got), 0);
                end else begin
                    want = line_col_q.pop_front();
                    if (got.line != want.line)
                        report_mismatch("line", got.line, want.line);
                    if (got.column != want.column)
                        report_mismatch("column", got.column, want.column);
                    if (got.full != want.full)
                        report_mismatch("table_full", got.full, want.full);
                end
            end
            if (s_tvalid && s_tready)
                line_col_q.push_back(apply_request(op_t'(s_tuser), s_tdata[POS_W-1:0]));
        end
        outstanding <= line_col_q.size();
    end

endmodule

>>> dv/line_start_table_search_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// line_start_table_search_tb
// Drives append, lookup, clear and no-op requests into the line start table
// search block under varying idle and stall patterns; a side checker
// predicts every result. Covers field extremes, unsorted tables, a
// completely filled table and a long output stall that backs up the input.
// ============================================================================
module line_start_table_search_tb;
    import lsts_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;  // long output hold for back-pressure
    localparam int TAIL_CYCLES  = 64;   // slack for a worst-case lookup plus output reg
    localparam int PHASE_REQS   = 15;   // requests per small-document phase

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [30:0] position
    logic [MODE_W-1:0]      s_tuser  = '0;   // [1:0] mode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [10:0] line, [42:11] column
    logic                   m_tuser;         // [0] table_full

    int mismatch_count;
    int outstanding;
    int cycle_count    = 0;
    int req_count      = 0;   // requests sent, no-ops excluded
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // Long hold handshake: stimulus toggles hold_req, receiver follows.
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    line_start_table_search u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lsts_line_col_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold when requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic logic [POS_W-1:0] rand_pos();
        logic [31:0] w;
        w = $urandom;
        return w[POS_W-1:0];
    endfunction

    // One request; returns at the edge where it is taken. Valid stays high
    // into the next call, which either keeps it up or drops it once.
    task automatic push_req(input op_t op, input logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-POS_W){1'b0}}, pos};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op != OP_NOP)
            req_count++;
    endtask

    task automatic noise_req();
        case ($urandom_range(0, 3))
            0: push_req(OP_NOP, rand_pos());
            1: push_req(OP_APPEND, rand_pos());
            2: push_req(OP_LOOKUP, rand_pos());
            default: push_req(OP_CLEAR, rand_pos());
        endcase
    endtask

    // One "file": clear, mostly ascending line starts with some lookups mixed
    // in, then lookups aimed at, just below and just past the starts.
    task automatic run_document(input int n_starts, input int n_lookups,
                                input int mix_pct, input int noise_pct,
                                input int big_shift_min);
        logic [POS_W-1:0] doc_starts [$];
        logic [31:0]      cursor;
        logic [31:0]      gap;
        logic [31:0]      t;
        logic [POS_W-1:0] base;
        int               sel;
        push_req(OP_CLEAR, rand_pos());
        doc_starts.push_back('0);
        cursor = '0;
        if (big_shift_min < 8 && $urandom_range(0, 3) == 0)
            cursor = {1'b0, rand_pos()} >> $urandom_range(0, 30);
        for (int i = 0; i < n_starts + n_lookups; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                noise_req();
            end else if (i < n_starts) begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    gap = 0;                       // duplicate start (empty line)
                else if (sel == 1)
                    gap = $urandom >> $urandom_range(big_shift_min, 31);
                else
                    gap = $urandom_range(1, 200);
                cursor = cursor + gap;
                if (cursor[31])                    // ran past max: goes unsorted
                    cursor = {1'b0, rand_pos()} >> $urandom_range(1, 30);
                push_req(OP_APPEND, cursor[POS_W-1:0]);
                doc_starts.push_back(cursor[POS_W-1:0]);
            end
            if ($urandom_range(0, 99) < mix_pct || i >= n_starts) begin
                base = doc_starts[$urandom_range(0, doc_starts.size() - 1)];
                sel  = $urandom_range(0, 9);
                if (sel < 4)
                    t = {1'b0, base};
                else if (sel < 6)
                    t = {1'b0, base} - 32'd1;
                else if (sel < 9)
                    t = {1'b0, base} + $urandom_range(0, 300);
                else
                    t = {1'b0, rand_pos()};
                push_req(OP_LOOKUP, t[POS_W-1:0]);
            end
        end
    endtask

    initial begin
        int phase_start;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed ----
        // fresh table: only entry 0
        push_req(OP_LOOKUP, 31'h0);
        push_req(OP_LOOKUP, 31'h7FFF_FFFF);        // widest column
        push_req(OP_NOP,    31'h5555_5555);        // unused mode code
        push_req(OP_NOP,    31'h2AAA_AAAA);
        push_req(OP_APPEND, 31'h10);
        push_req(OP_APPEND, 31'h10);               // duplicate start
        push_req(OP_APPEND, 31'h7FFF_FFFF);        // max offset
        push_req(OP_LOOKUP, 31'hF);
        push_req(OP_LOOKUP, 31'h10);
        push_req(OP_LOOKUP, 31'h7FFF_FFFE);
        push_req(OP_LOOKUP, 31'h7FFF_FFFF);
        push_req(OP_APPEND, 31'h5);                // out of order append
        push_req(OP_LOOKUP, 31'h6);
        push_req(OP_LOOKUP, 31'h3);
        push_req(OP_CLEAR,  rand_pos());
        push_req(OP_LOOKUP, 31'h12345);
        push_req(OP_APPEND, 31'h0);                // same as entry 0
        push_req(OP_LOOKUP, 31'h0);
        push_req(OP_APPEND, 31'h4000_0000);
        push_req(OP_LOOKUP, 31'h3FFF_FFFF);
        push_req(OP_LOOKUP, 31'h4000_0000);
        push_req(OP_CLEAR,  31'h7FFF_FFFF);

        // ---- random, by idle pattern ----
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            if (ph == 0)
                hold_req <= ~hold_req;             // back up the block early on
            if (ph == 3) begin
                // fill the table to the brim, overflow it, search it
                run_document(TABLE_DEPTH + 4, 30, 1, 0, 16);
            end else begin
                phase_start = req_count;
                while (req_count - phase_start < PHASE_REQS)
                    run_document($urandom_range(0, 40), $urandom_range(1, 25),
                                 20, 5, 2);
            end
        end

        s_tvalid <= 1'b0;

        // drain, then let any straggler show up
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
